[rtl/fcsg_pkg.sv]
// package for the filled circle span generator: widths, constants, sequencer types
`timescale 1ns / 1ps

package fcsg_pkg;

	localparam int COORD_W   = 10;
	localparam int RAD_W     = 6;
	localparam int COLOR_W   = 16;
	localparam int SQ_W      = 12;
	localparam int SUM_W     = 13;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	// r*707/1000 as a reciprocal multiply, exact for every 6-bit radius
	localparam int RECIP_W     = 24;
	localparam int LIMIT_SHIFT = 24;
	localparam logic [RECIP_W-1:0] LIMIT_RECIP = 24'd11862046;
	localparam int PROD_W = RAD_W + RECIP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIM,
		ST_SQ,
		ST_CENTER,
		ST_STEP,
		ST_ROW
	} fcsg_state_t;

	typedef enum logic [1:0] {
		SPAN_CENTER,
		SPAN_PAIR,
		SPAN_ROW
	} fcsg_span_kind_t;

	typedef struct packed {
		logic            emit;
		fcsg_span_kind_t kind;
		logic            last;
		logic            step_x;
		logic            step_i;
	} fcsg_ctrl_t;

endpackage

[rtl/filled_circle_span_generator.sv]
// filled circle span generator: sequencer with one shared multiplier and one shared adder
// the first span (centre row) follows the ST_LIM and ST_SQ setup states, registered out of ST_CENTER
// the row loop runs i from 1 to limit, limit = r*707/1000+1, at most one adder step per cycle
// while the output is not stalled
// the block accepts a new circle only when its sequencer is idle
// reset: arst_n clears the sequencer and the output valid, payload registers are not reset
`timescale 1ns / 1ps

module filled_circle_span_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// center_x, center_y, radius, fill_color, zero pad
	input  logic [fcsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// span_left, span_right, row_below, row_above, span_color
	output logic [fcsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// is_pair
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import fcsg_pkg::*;

	fcsg_state_t state_q, state_d;
	fcsg_ctrl_t  ctrl;

	logic [COORD_W-1:0] cx_q, cy_q;
	logic [RAD_W-1:0]   r_q, x_q, i_q, limit_q;
	logic [COLOR_W-1:0] color_q;
	logic [SQ_W-1:0]    sqmax_q;
	logic [SUM_W-1:0]   s_q;

	logic [COORD_W-1:0] left_q, right_q, below_q, above_q;
	logic [COLOR_W-1:0] ocolor_q;
	logic               pair_q, last_q, ovalid_q;

	logic               out_free;
	logic               over;
	logic               do_pair;
	logic [RECIP_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   add_op, sum;
	logic [COORD_W-1:0] x_w, i_w, r_w, im1_w;
	logic [COORD_W-1:0] nl, nr, nb, na;

	assign out_free = !ovalid_q || m_axis_tready;
	assign over     = s_q > {1'b0, sqmax_q};
	assign do_pair  = over && (x_q > limit_q);

	// shared multiplier: reciprocal for the loop limit, then the radius square
	assign mul_b = (state_q == ST_LIM) ? LIMIT_RECIP : {{(RECIP_W-RAD_W){1'b0}}, r_q};
	assign prod  = {{RECIP_W{1'b0}}, r_q} * {{RAD_W{1'b0}}, mul_b};

	// shared adder: s - 2x + 1 when x steps down, s + 2i + 1 when i steps up
	assign add_op = ctrl.step_x ? (SUM_W'(0) - {{(SUM_W-RAD_W-1){1'b0}}, x_q, 1'b0})
		: {{(SUM_W-RAD_W-1){1'b0}}, i_q, 1'b0};
	assign sum = s_q + add_op + SUM_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_LIM;
			end
			ST_LIM: state_d = ST_SQ;
			ST_SQ: state_d = ST_CENTER;
			ST_CENTER: begin
				if (out_free) state_d = (r_q == '0) ? ST_IDLE : ST_STEP;
			end
			ST_STEP: begin
				if (!do_pair || out_free) state_d = ST_ROW;
			end
			ST_ROW: begin
				if (out_free) state_d = (i_q == limit_q) ? ST_IDLE : ST_STEP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '{emit: 1'b0, kind: SPAN_CENTER, last: 1'b0, step_x: 1'b0, step_i: 1'b0};
		case (state_q)
			ST_CENTER: begin
				ctrl.emit = out_free;
				ctrl.kind = SPAN_CENTER;
				ctrl.last = (r_q == '0);
			end
			ST_STEP: begin
				if (!do_pair || out_free) begin
					ctrl.emit   = do_pair;
					ctrl.kind   = SPAN_PAIR;
					ctrl.step_x = over && (x_q != '0);
				end
			end
			ST_ROW: begin
				ctrl.emit   = out_free;
				ctrl.kind   = SPAN_ROW;
				ctrl.last   = (i_q == limit_q);
				ctrl.step_i = out_free;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// span coordinates
	assign x_w   = {{(COORD_W-RAD_W){1'b0}}, x_q};
	assign i_w   = {{(COORD_W-RAD_W){1'b0}}, i_q};
	assign r_w   = {{(COORD_W-RAD_W){1'b0}}, r_q};
	assign im1_w = i_w - COORD_W'(1);

	always_comb begin
		case (ctrl.kind)
			SPAN_PAIR: begin
				nl = cx_q - im1_w;
				nr = cx_q + im1_w;
				nb = cy_q + x_w;
				na = cy_q - x_w;
			end
			SPAN_ROW: begin
				nl = cx_q - x_w;
				nr = cx_q + x_w;
				nb = cy_q + i_w;
				na = cy_q - i_w;
			end
			default: begin
				nl = cx_q - r_w;
				nr = cx_q + r_w;
				nb = cy_q;
				na = cy_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.emit) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cx_q    <= s_axis_tdata[9:0];
			cy_q    <= s_axis_tdata[19:10];
			r_q     <= s_axis_tdata[25:20];
			color_q <= s_axis_tdata[41:26];
		end
		if (state_q == ST_LIM) begin
			limit_q <= prod[LIMIT_SHIFT +: RAD_W] + RAD_W'(1);
		end
		if (state_q == ST_SQ) begin
			sqmax_q <= prod[SQ_W-1:0] + {{(SQ_W-RAD_W+1){1'b0}}, r_q[RAD_W-1:1]};
			s_q     <= prod[SUM_W-1:0] + SUM_W'(1);
			x_q     <= r_q;
			i_q     <= RAD_W'(1);
		end
		if (ctrl.step_x) begin
			x_q <= x_q - RAD_W'(1);
			s_q <= sum;
		end
		if (ctrl.step_i) begin
			i_q <= i_q + RAD_W'(1);
			s_q <= sum;
		end
		if (ctrl.emit) begin
			left_q   <= nl;
			right_q  <= nr;
			below_q  <= nb;
			above_q  <= na;
			ocolor_q <= color_q;
			pair_q   <= (ctrl.kind != SPAN_CENTER);
			last_q   <= ctrl.last;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {ocolor_q, above_q, below_q, right_q, left_q};
	assign m_axis_tuser  = pair_q;
	assign m_axis_tlast  = last_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_LIM)
		else $error("accepted circle did not start the setup");

	a_i_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_ROW) |-> (i_q != '0 && i_q <= limit_q))
		else $error("row offset outside 1..limit");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_ROW) |-> x_q <= r_q)
		else $error("x above radius");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_ROW)
		|-> s_q == SUM_W'(i_q) * SUM_W'(i_q) + SUM_W'(x_q) * SUM_W'(x_q))
		else $error("running sum lost track of i*i+x*x");

endmodule

[tb/tb_top.sv]
// testbench for the filled circle span generator: span scoreboard, stream drivers and checks
`timescale 1ns / 1ps

module tb_top;

	import fcsg_pkg::*;

	typedef struct {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [RAD_W-1:0]   rad;
		logic [COLOR_W-1:0] color;
	} circle_t;

	typedef struct {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] below;
		logic [COORD_W-1:0] above;
		logic               pair;
		logic [COLOR_W-1:0] color;
		logic               last;
	} span_t;

	class span_scoreboard;
		span_t expected_spans[$];
		int    mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		function int pending();
			return expected_spans.size();
		endfunction

		// works out the spans of one accepted circle, keeping at most 64 of them
		function void note_circle(circle_t c);
			span_t batch[$];
			span_t s;
			int    cx;
			int    cy;
			int    r;
			int    lim;
			int    sqmax;
			int    x;
			cx = c.cx;
			cy = c.cy;
			r = c.rad;
			s.color = c.color;
			s.last = 1'b0;
			if (r == 0) begin
				s.left = c.cx;
				s.right = c.cx;
				s.below = c.cy;
				s.above = c.cy;
				s.pair = 1'b0;
				batch.push_back(s);
			end else begin
				lim = r * 707 / 1000 + 1;
				sqmax = r * r + r / 2;
				x = r;
				s.left = COORD_W'(cx - r);
				s.right = COORD_W'(cx + r);
				s.below = c.cy;
				s.above = c.cy;
				s.pair = 1'b0;
				batch.push_back(s);
				s.pair = 1'b1;
				for (int i = 1; i <= lim; i++) begin
					if (i * i + x * x > sqmax) begin
						if (x > lim && batch.size() < 64) begin
							s.left = COORD_W'(cx - i + 1);
							s.right = COORD_W'(cx + i - 1);
							s.below = COORD_W'(cy + x);
							s.above = COORD_W'(cy - x);
							batch.push_back(s);
						end
						if (x > 0)
							x--;
					end
					if (batch.size() < 64) begin
						s.left = COORD_W'(cx - x);
						s.right = COORD_W'(cx + x);
						s.below = COORD_W'(cy + i);
						s.above = COORD_W'(cy - i);
						batch.push_back(s);
					end
				end
			end
			batch[batch.size() - 1].last = 1'b1;
			foreach (batch[k])
				expected_spans.push_back(batch[k]);
		endfunction

		function void check_span(logic [OUT_DATA_W-1:0] data, logic pair, logic last);
			span_t e;
			span_t a;
			a.left = data[9:0];
			a.right = data[19:10];
			a.below = data[29:20];
			a.above = data[39:30];
			a.color = data[55:40];
			a.pair = pair;
			a.last = last;
			if (expected_spans.size() == 0) begin
				$display("%0t: span with none expected: left %0d right %0d below %0d above %0d",
					$time, a.left, a.right, a.below, a.above);
				mismatch_count++;
				return;
			end
			e = expected_spans.pop_front();
			if (a.left !== e.left) begin
				$display("%0t: span_left expected %0d actual %0d", $time, e.left, a.left);
				mismatch_count++;
			end
			if (a.right !== e.right) begin
				$display("%0t: span_right expected %0d actual %0d", $time, e.right, a.right);
				mismatch_count++;
			end
			if (a.below !== e.below) begin
				$display("%0t: row_below expected %0d actual %0d", $time, e.below, a.below);
				mismatch_count++;
			end
			if (a.above !== e.above) begin
				$display("%0t: row_above expected %0d actual %0d", $time, e.above, a.above);
				mismatch_count++;
			end
			if (a.pair !== e.pair) begin
				$display("%0t: is_pair expected %0b actual %0b", $time, e.pair, a.pair);
				mismatch_count++;
			end
			if (a.color !== e.color) begin
				$display("%0t: span_color expected %h actual %h", $time, e.color, a.color);
				mismatch_count++;
			end
			if (a.last !== e.last) begin
				$display("%0t: last_span expected %0b actual %0b", $time, e.last, a.last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	span_scoreboard sb;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             holdoff_request;
	int             holdoff_left;

	filled_circle_span_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holdoff_request = 0;
		holdoff_left = 0;
		sb = new();
	end

	always #5 clk = ~clk;

	// accepted transactions on both sides
	always @(posedge clk) begin
		circle_t c;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			c.cx = s_axis_tdata[9:0];
			c.cy = s_axis_tdata[19:10];
			c.rad = s_axis_tdata[25:20];
			c.color = s_axis_tdata[41:26];
			sb.note_circle(c);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_span(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (holdoff_request > 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_circle(input circle_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, c.color, c.rad, c.cy, c.cx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_random_circle();
		circle_t c;
		c.cx = COORD_W'($urandom);
		c.cy = COORD_W'($urandom);
		c.color = COLOR_W'($urandom);
		case ($urandom_range(0, 9))
			0: c.rad = RAD_W'($urandom_range(0, 1));
			1: c.rad = 6'd63;
			default: c.rad = RAD_W'($urandom_range(0, 63));
		endcase
		send_circle(c);
	endtask

	// waits for a clock edge before polling, so the last accepted circle is already in the scoreboard
	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		circle_t directed[$];
		circle_t c;
		directed.push_back('{10'd0, 10'd0, 6'd0, 16'h0000});
		directed.push_back('{10'd1023, 10'd1023, 6'd0, 16'hFFFF});
		directed.push_back('{10'd1023, 10'd1023, 6'd1, 16'hFFFF});
		directed.push_back('{10'd0, 10'd1023, 6'd1, 16'h0001});
		directed.push_back('{10'd0, 10'd0, 6'd63, 16'hAAAA});
		directed.push_back('{10'd1023, 10'd1023, 6'd63, 16'h5555});
		directed.push_back('{10'd512, 10'd512, 6'd63, 16'hF800});
		directed.push_back('{10'd512, 10'd512, 6'd2, 16'h07E0});
		directed.push_back('{10'd100, 10'd200, 6'd3, 16'h001F});
		directed.push_back('{10'd300, 10'd400, 6'd4, 16'h8000});
		directed.push_back('{10'd5, 10'd1020, 6'd5, 16'h1234});
		directed.push_back('{10'd1020, 10'd5, 6'd7, 16'hFEDC});
		directed.push_back('{10'd682, 10'd341, 6'd8, 16'h0F0F});
		directed.push_back('{10'd341, 10'd682, 6'd10, 16'hF0F0});
		directed.push_back('{10'd7, 10'd9, 6'd16, 16'h7FFF});
		directed.push_back('{10'd1016, 10'd1000, 6'd31, 16'hC3C3});
		directed.push_back('{10'd30, 10'd1010, 6'd32, 16'h3C3C});
		directed.push_back('{10'd600, 10'd60, 6'd62, 16'h0000});
		directed.push_back('{10'd21, 10'd42, 6'd42, 16'h5A5A});
		directed.push_back('{10'd555, 10'd777, 6'd21, 16'hA5A5});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_circle(directed[k]);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 52;
				end
				1: begin
					send_idle_pct = 52;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 100; n++) begin
				if (phase == 0 && n == 40)
					holdoff_request = 500;
				if (phase == 1 && n == 50) begin
					s_axis_tvalid <= 1'b0;
					wait_drained();
				end
				send_random_circle();
			end
		end
		c = '{10'd1023, 10'd0, 6'd63, 16'hFFFF};
		send_circle(c);
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (120) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
